@@ hdl/hsvrgb_pkg.sv @@
// Shared types, constants and the sector routing function for the HSV to RGB converter.
`default_nettype none

package hsvrgb_pkg;

	localparam int unsigned HUE_W    = 9;
	localparam int unsigned PCT_W    = 7;
	localparam int unsigned CHAN_W   = 8;
	localparam int unsigned DEG_W    = 6;
	localparam int unsigned VS_W     = 14;
	localparam int unsigned V60_W    = 13;
	localparam int unsigned NUM_W    = 20;
	localparam int unsigned BIAS_W   = 24;
	localparam int unsigned CEIL_SH  = 6;
	localparam int unsigned SCALED_W = BIAS_W - CEIL_SH;
	localparam int unsigned RECIP_W  = 19;
	localparam int unsigned PROD_W   = SCALED_W + RECIP_W;
	localparam int unsigned RECIP_SH = 28;
	localparam int unsigned QUOT_W   = PROD_W - RECIP_SH;

	localparam logic [HUE_W-1:0]  HUE_WRAP   = 9'd360;
	localparam logic [PCT_W-1:0]  PCT_FULL   = 7'd100;
	localparam logic [DEG_W-1:0]  SECTOR_DEG = 6'd60;
	localparam logic [BIAS_W-1:0] SCALE_MUL  = 24'd17;
	localparam logic [BIAS_W-1:0] CEIL_BIAS  = 24'd39999;
	localparam logic [RECIP_W-1:0] RECIP_625 = 19'd429497;

	typedef enum logic [2:0] {
		SEC_RED_YELLOW    = 3'd0,
		SEC_YELLOW_GREEN  = 3'd1,
		SEC_GREEN_CYAN    = 3'd2,
		SEC_CYAN_BLUE     = 3'd3,
		SEC_BLUE_MAGENTA  = 3'd4,
		SEC_MAGENTA_RED   = 3'd5
	} sector_t;

	typedef struct packed {
		logic s1;
		logic s2;
		logic s3;
	} front_en_t;

	typedef struct packed {
		logic s4;
		logic s5;
		logic s6;
	} scale_en_t;

	typedef struct packed {
		logic [NUM_W-1:0] red;
		logic [NUM_W-1:0] green;
		logic [NUM_W-1:0] blue;
	} chan_num_t;

	// Places chroma, the secondary component and zero on the channels, each plus the offset.
	// Every sum stays at or below 600000, so it fits the numerator width.
	function automatic chan_num_t route(sector_t sec, logic [NUM_W-1:0] c,
			logic [NUM_W-1:0] x, logic [NUM_W-1:0] m);
		chan_num_t res;
		res.red   = m;
		res.green = m;
		res.blue  = m;
		case (sec)
			SEC_RED_YELLOW: begin
				res.red   = c + m;
				res.green = x + m;
			end
			SEC_YELLOW_GREEN: begin
				res.red   = x + m;
				res.green = c + m;
			end
			SEC_GREEN_CYAN: begin
				res.green = c + m;
				res.blue  = x + m;
			end
			SEC_CYAN_BLUE: begin
				res.green = x + m;
				res.blue  = c + m;
			end
			SEC_BLUE_MAGENTA: begin
				res.red   = x + m;
				res.blue  = c + m;
			end
			default: begin
				res.red   = c + m;
				res.blue  = x + m;
			end
		endcase
		return res;
	endfunction

endpackage

`default_nettype wire

@@ hdl/hsvrgb_if.sv @@
// Valid/ready channel interfaces for the HSV input pixels and the RGB result pixels.
`default_nettype none

interface hsvrgb_in_if;
	logic                             valid;
	logic                             ready;
	logic [hsvrgb_pkg::HUE_W-1:0]     hue_deg;
	logic [hsvrgb_pkg::PCT_W-1:0]     saturation_pct;
	logic [hsvrgb_pkg::PCT_W-1:0]     brightness_pct;

	modport source (output valid, output hue_deg, output saturation_pct,
		output brightness_pct, input ready);
	modport sink (input valid, input hue_deg, input saturation_pct,
		input brightness_pct, output ready);
endinterface

interface hsvrgb_out_if;
	logic                             valid;
	logic                             ready;
	logic [hsvrgb_pkg::CHAN_W-1:0]    red;
	logic [hsvrgb_pkg::CHAN_W-1:0]    green;
	logic [hsvrgb_pkg::CHAN_W-1:0]    blue;

	modport source (output valid, output red, output green, output blue, input ready);
	modport sink (input valid, input red, input green, input blue, output ready);
endinterface

`default_nettype wire

@@ hdl/hsvrgb_front.sv @@
// Front stages: hue wrap and clamping, sector and hue distance, then chroma, secondary and offset.
`default_nettype none

module hsvrgb_front (
	input  wire logic                          clk,
	input  wire hsvrgb_pkg::front_en_t         en,
	input  wire logic [hsvrgb_pkg::HUE_W-1:0]  hue_deg,
	input  wire logic [hsvrgb_pkg::PCT_W-1:0]  saturation_pct,
	input  wire logic [hsvrgb_pkg::PCT_W-1:0]  brightness_pct,
	output hsvrgb_pkg::sector_t                sector,
	output logic [hsvrgb_pkg::NUM_W-1:0]       chroma,
	output logic [hsvrgb_pkg::NUM_W-1:0]       second,
	output logic [hsvrgb_pkg::NUM_W-1:0]       offset
);

	localparam int unsigned HueW = hsvrgb_pkg::HUE_W;
	localparam int unsigned PctW = hsvrgb_pkg::PCT_W;
	localparam int unsigned DegW = hsvrgb_pkg::DEG_W;
	localparam int unsigned VsW  = hsvrgb_pkg::VS_W;
	localparam int unsigned V60W = hsvrgb_pkg::V60_W;
	localparam int unsigned NumW = hsvrgb_pkg::NUM_W;

	logic [HueW-1:0] hue_s1;
	logic [PctW-1:0] sat_s1;
	logic [PctW-1:0] bri_s1;

	hsvrgb_pkg::sector_t sector_s2;
	logic [DegW-1:0]     dist_s2;
	logic [VsW-1:0]      vs_s2;
	logic [V60W-1:0]     v60_s2;
	logic [PctW-1:0]     sinv_s2;

	hsvrgb_pkg::sector_t sector_s3;
	logic [NumW-1:0]     chroma_s3;
	logic [NumW-1:0]     second_s3;
	logic [NumW-1:0]     offset_s3;

	logic [HueW-1:0]     hue_wrap;
	logic [PctW-1:0]     sat_clamp;
	logic [PctW-1:0]     bri_clamp;
	hsvrgb_pkg::sector_t sector_c;
	logic [HueW-1:0]     pair_base;
	logic [HueW-1:0]     hue_in_pair;
	logic [DegW-1:0]     dist_c;

	// Stage 1: the input range up to 511 needs only one wrap by 360.
	always_comb begin
		hue_wrap  = (hue_deg >= hsvrgb_pkg::HUE_WRAP) ? hue_deg - hsvrgb_pkg::HUE_WRAP : hue_deg;
		sat_clamp = (saturation_pct > hsvrgb_pkg::PCT_FULL) ? hsvrgb_pkg::PCT_FULL : saturation_pct;
		bri_clamp = (brightness_pct > hsvrgb_pkg::PCT_FULL) ? hsvrgb_pkg::PCT_FULL : brightness_pct;
	end

	always_ff @(posedge clk) begin
		if (en.s1) begin
			hue_s1 <= hue_wrap;
			sat_s1 <= sat_clamp;
			bri_s1 <= bri_clamp;
		end
	end

	// Stage 2: sector by comparison, and the distance of the hue from the middle of its
	// 120-degree pair of sectors.
	always_comb begin
		if (hue_s1 < 9'd60) begin
			sector_c  = hsvrgb_pkg::SEC_RED_YELLOW;
			pair_base = 9'd0;
		end else if (hue_s1 < 9'd120) begin
			sector_c  = hsvrgb_pkg::SEC_YELLOW_GREEN;
			pair_base = 9'd0;
		end else if (hue_s1 < 9'd180) begin
			sector_c  = hsvrgb_pkg::SEC_GREEN_CYAN;
			pair_base = 9'd120;
		end else if (hue_s1 < 9'd240) begin
			sector_c  = hsvrgb_pkg::SEC_CYAN_BLUE;
			pair_base = 9'd120;
		end else if (hue_s1 < 9'd300) begin
			sector_c  = hsvrgb_pkg::SEC_BLUE_MAGENTA;
			pair_base = 9'd240;
		end else begin
			sector_c  = hsvrgb_pkg::SEC_MAGENTA_RED;
			pair_base = 9'd240;
		end
		hue_in_pair = hue_s1 - pair_base;
		if (hue_in_pair >= HueW'(hsvrgb_pkg::SECTOR_DEG)) begin
			dist_c = DegW'(hue_in_pair - HueW'(hsvrgb_pkg::SECTOR_DEG));
		end else begin
			dist_c = DegW'(HueW'(hsvrgb_pkg::SECTOR_DEG) - hue_in_pair);
		end
	end

	always_ff @(posedge clk) begin
		if (en.s2) begin
			sector_s2 <= sector_c;
			dist_s2   <= dist_c;
			vs_s2     <= VsW'(sat_s1) * VsW'(bri_s1);
			v60_s2    <= V60W'(bri_s1) * V60W'(hsvrgb_pkg::SECTOR_DEG);
			sinv_s2   <= hsvrgb_pkg::PCT_FULL - sat_s1;
		end
	end

	// Stage 3: the three terms over the common denominator 600000.
	always_ff @(posedge clk) begin
		if (en.s3) begin
			sector_s3 <= sector_s2;
			chroma_s3 <= NumW'(vs_s2) * NumW'(hsvrgb_pkg::SECTOR_DEG);
			second_s3 <= NumW'(vs_s2) * NumW'(hsvrgb_pkg::SECTOR_DEG - dist_s2);
			offset_s3 <= NumW'(v60_s2) * NumW'(sinv_s2);
		end
	end

	assign sector = sector_s3;
	assign chroma = chroma_s3;
	assign second = second_s3;
	assign offset = offset_s3;

endmodule

`default_nettype wire

@@ hdl/hsvrgb_scale.sv @@
// Channel scaling stages: ceiling of numerator times 255 over 600000, saturated to eight bits.
`default_nettype none

module hsvrgb_scale (
	input  wire logic                          clk,
	input  wire hsvrgb_pkg::scale_en_t         en,
	input  wire logic [hsvrgb_pkg::NUM_W-1:0]  num,
	output logic [hsvrgb_pkg::CHAN_W-1:0]      chan
);

	localparam int unsigned BiasW   = hsvrgb_pkg::BIAS_W;
	localparam int unsigned ScaledW = hsvrgb_pkg::SCALED_W;
	localparam int unsigned ProdW   = hsvrgb_pkg::PROD_W;
	localparam int unsigned QuotW   = hsvrgb_pkg::QUOT_W;
	localparam int unsigned ChanW   = hsvrgb_pkg::CHAN_W;

	logic [BiasW-1:0]   biased;
	logic [ScaledW-1:0] scaled_s4;
	logic [ProdW-1:0]   prod_s5;
	logic [QuotW-1:0]   quot;
	logic [ChanW-1:0]   chan_s6;

	// 255/600000 reduces to 17/40000. The ceiling bias is added before the split into a
	// shift by 64 and a division by 625.
	assign biased = BiasW'(num) * hsvrgb_pkg::SCALE_MUL + hsvrgb_pkg::CEIL_BIAS;

	always_ff @(posedge clk) begin
		if (en.s4) begin
			scaled_s4 <= biased[BiasW-1:hsvrgb_pkg::CEIL_SH];
		end
	end

	// Division by 625 as a multiply by the rounded-up reciprocal; exact over this input range.
	always_ff @(posedge clk) begin
		if (en.s5) begin
			prod_s5 <= ProdW'(scaled_s4) * ProdW'(hsvrgb_pkg::RECIP_625);
		end
	end

	assign quot = prod_s5[ProdW-1:hsvrgb_pkg::RECIP_SH];

	always_ff @(posedge clk) begin
		if (en.s6) begin
			chan_s6 <= (quot > QuotW'({ChanW{1'b1}})) ? {ChanW{1'b1}} : quot[ChanW-1:0];
		end
	end

	assign chan = chan_s6;

endmodule

`default_nettype wire

@@ hdl/hsv_to_rgb_converter.sv @@
// Six register stages, s1 to s6. Throughput: one pixel per clock while pix_out is ready;
// each stage moves on when the stage after it is empty or moving, so bubbles close up
// and a stalled output holds only the stages behind it.
// The multipliers of the chroma terms and of the reciprocal division set the stage split.
// Reset (arst_n low, asynchronous) clears the valid bits; the data registers are not reset.
`default_nettype none

module hsv_to_rgb_converter (
	input  wire logic    clk,
	input  wire logic    arst_n,
	hsvrgb_in_if.sink    pix_in,
	hsvrgb_out_if.source pix_out
);

	localparam int unsigned NumW = hsvrgb_pkg::NUM_W;

	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6;
	logic en_s1, en_s2, en_s3, en_s4, en_s5, en_s6;

	hsvrgb_pkg::front_en_t front_en;
	hsvrgb_pkg::scale_en_t scale_en;
	hsvrgb_pkg::sector_t   sector;
	hsvrgb_pkg::chan_num_t nums;
	logic [NumW-1:0]       chroma;
	logic [NumW-1:0]       second;
	logic [NumW-1:0]       offset;

	always_comb begin
		en_s6 = !vld_s6 || pix_out.ready;
		en_s5 = !vld_s5 || en_s6;
		en_s4 = !vld_s4 || en_s5;
		en_s3 = !vld_s3 || en_s4;
		en_s2 = !vld_s2 || en_s3;
		en_s1 = !vld_s1 || en_s2;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
		end else begin
			if (en_s1) vld_s1 <= pix_in.valid;
			if (en_s2) vld_s2 <= vld_s1;
			if (en_s3) vld_s3 <= vld_s2;
			if (en_s4) vld_s4 <= vld_s3;
			if (en_s5) vld_s5 <= vld_s4;
			if (en_s6) vld_s6 <= vld_s5;
		end
	end

	assign front_en = '{s1: en_s1, s2: en_s2, s3: en_s3};
	assign scale_en = '{s4: en_s4, s5: en_s5, s6: en_s6};

	hsvrgb_front u_front (
		.clk            (clk),
		.en             (front_en),
		.hue_deg        (pix_in.hue_deg),
		.saturation_pct (pix_in.saturation_pct),
		.brightness_pct (pix_in.brightness_pct),
		.sector         (sector),
		.chroma         (chroma),
		.second         (second),
		.offset         (offset)
	);

	assign nums = hsvrgb_pkg::route(sector, chroma, second, offset);

	hsvrgb_scale u_scale_red (
		.clk  (clk),
		.en   (scale_en),
		.num  (nums.red),
		.chan (pix_out.red)
	);

	hsvrgb_scale u_scale_green (
		.clk  (clk),
		.en   (scale_en),
		.num  (nums.green),
		.chan (pix_out.green)
	);

	hsvrgb_scale u_scale_blue (
		.clk  (clk),
		.en   (scale_en),
		.num  (nums.blue),
		.chan (pix_out.blue)
	);

	assign pix_in.ready  = en_s1;
	assign pix_out.valid = vld_s6;

	// With the output stage empty, every stage can move, so a beat must be taken.
	a_ready_when_drained: assert property (@(posedge clk) disable iff (!arst_n)
		!pix_out.valid |-> pix_in.ready)
		else $error("input not ready although the output stage is empty");

	// An item in the last internal stage that is allowed to move reaches the output.
	a_last_stage_moves: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s5 && en_s6) |=> pix_out.valid)
		else $error("item lost between the last two stages");

	// A full pipeline behind a stalled output must refuse new beats.
	a_full_stall_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		(pix_out.valid && !pix_out.ready && vld_s1 && vld_s2 && vld_s3 && vld_s4 && vld_s5)
		|-> !pix_in.ready)
		else $error("beat accepted into a full stalled pipeline");

endmodule

`default_nettype wire
